// ===== rtl/ultrasonic_echo_ranger_unit_assert.svh =====
// Assertion macros for the ultrasonic echo ranger RTL.
// Included by the modules that check their own logic; needs clock and reset in scope.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define UER_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the following edge.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: phase codes, register indexes and
// fixed-point constants for the distance conversion. No dependencies.
`default_nettype none

package uer_pkg;

   localparam int CountWidth = 16;
   localparam int UsWidth    = 15;
   localparam int UsCmpWidth = (CountWidth - 1 > UsWidth) ? CountWidth - 1 : UsWidth;

   localparam logic [2:0] PhReady   = 3'd0;
   localparam logic [2:0] PhSettle  = 3'd1;
   localparam logic [2:0] PhPulse   = 3'd2;
   localparam logic [2:0] PhWait    = 3'd3;
   localparam logic [2:0] PhMeasure = 3'd4;
   localparam logic [2:0] PhDone    = 3'd5;

   localparam logic CsrSettle = 1'b0;
   localparam logic CsrPulse  = 1'b1;

   localparam logic [7:0] SettleReset = 8'd4;
   localparam logic [7:0] PulseReset  = 8'd20;

   localparam logic [8:0] CmMax = 9'd400;

   // Microseconds at which the distance reaches 401 cm; anything longer saturates.
   localparam logic [UsWidth-1:0] UsSatMax = 15'd23258;

   // Division by 58 as a multiplication by a rounded-up reciprocal.
   localparam int          CmShift = 21;
   localparam logic [15:0] CmRecip = 16'd36158;

   // Scaling by 255/400 folded into one reciprocal multiplication.
   localparam int          ByteShift = 26;
   localparam logic [25:0] ByteRecip = 26'd42782115;

   typedef struct packed {
      logic trigger;
      logic ready;
      logic busy;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
// Ultrasonic echo ranger, top level: phase control, tick counting and the
// pipelined conversion of echo length to centimetres and a scaled byte.
// Depends on uer_pkg and ultrasonic_echo_ranger_unit_assert.svh.
//
// Usage: every 0.5 us timer tick the source presents one item on req_ with the
// sampled echo level and the start and clear requests. Each accepted item gives
// exactly one result item on rsp_, carrying the trigger drive level, the ready
// and busy flags and the held distance in centimetres and as a byte.
// The pipeline has three register stages: control and echo length, division
// by 58, and the byte scaling, through which each item passes in that order.
// One item can be accepted every cycle while the pipeline is not stalled.
// The csr_ port writes the settle and pulse lengths in ticks; write it only
// while no items are in flight.
// Reset clears the phase to ready, the tick counter and the held reading, and
// restores the register defaults. When rsp_tready is low with a result shown,
// the whole pipeline stalls and req_tready falls until the result is taken.
`default_nettype none
`include "ultrasonic_echo_ranger_unit_assert.svh"

module ultrasonic_echo_ranger_unit
   import uer_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] echo_level, [1] start_request, [2] clear_request, [7:3] zero
   input  wire logic [7:0]  req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] trigger_out, [1] reading_ready, [2] busy_res, [11:3] distance_cm,
   // [19:12] distance_byte, [23:20] zero
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]            settle_ticks_ff;
   logic [7:0]            pulse_ticks_ff;

   logic [2:0]            phase_ff;
   logic [2:0]            phase_in;
   logic [CountWidth-1:0] tick_count_ff;
   logic [CountWidth-1:0] tick_count_in;
   logic [CountWidth-1:0] echo_start_ff;
   logic [CountWidth-1:0] echo_start_in;
   logic [7:0]            phase_timer_ff;
   logic [7:0]            phase_timer_in;

   logic                  pipe_en;
   logic                  accept;
   logic                  echo_level;
   logic                  start_request;
   logic                  clear_request;

   flags_type             flags_in;
   logic                  fin_in;
   logic [UsWidth-1:0]    us_in;

   logic                  s1_valid_ff;
   flags_type             s1_flags_ff;
   logic                  s1_fin_ff;
   logic [UsWidth-1:0]    s1_us_ff;

   logic [30:0]           cm_prod;
   logic [9:0]            cm_raw;
   logic [8:0]            cm_in;

   logic                  s2_valid_ff;
   flags_type             s2_flags_ff;
   logic                  s2_fin_ff;
   logic [8:0]            s2_cm_ff;

   logic [34:0]           byte_prod;
   logic [7:0]            byte_in;

   logic                  rsp_tvalid_ff;
   flags_type             rsp_flags_ff;
   logic [8:0]            held_cm_ff;
   logic [7:0]            held_byte_ff;

   assign pipe_en       = !rsp_tvalid_ff || rsp_tready;
   assign req_tready    = pipe_en;
   assign accept        = req_tvalid && pipe_en;
   assign echo_level    = req_tdata[0];
   assign start_request = req_tdata[1];
   assign clear_request = req_tdata[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= SettleReset;
         pulse_ticks_ff  <= PulseReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrSettle: settle_ticks_ff <= csr_wdata;
            CsrPulse:  pulse_ticks_ff  <= csr_wdata;
            default:   settle_ticks_ff <= settle_ticks_ff;
         endcase
      end
   end

   always_comb begin
      logic [2:0]            ph;
      logic [7:0]            tmr;
      logic [CountWidth-1:0] tc;
      logic [CountWidth-1:0] es;
      logic [CountWidth-1:0] diff;
      logic [UsCmpWidth-1:0] us_wide;
      logic                  fin;

      ph  = (phase_ff > PhDone) ? PhReady : phase_ff;
      tmr = phase_timer_ff;
      tc  = tick_count_ff;
      es  = echo_start_ff;
      fin = 1'b0;

      if (clear_request) begin
         ph  = PhReady;
         tmr = 8'd0;
      end else begin
         case (ph)
            PhReady: begin
               if (start_request) begin
                  tc  = '0;
                  ph  = PhSettle;
                  tmr = settle_ticks_ff;
               end
            end
            PhSettle, PhPulse: begin
               if (tmr != 8'd0) begin
                  tmr = tmr - 8'd1;
               end
            end
            PhWait: begin
               if (echo_level) begin
                  es = tc;
                  ph = PhMeasure;
               end
            end
            PhMeasure: begin
               if (!echo_level) begin
                  fin = 1'b1;
                  ph  = PhDone;
               end
            end
            default: begin
               ph = ph;
            end
         endcase

         if (ph == PhSettle && tmr == 8'd0) begin
            ph  = PhPulse;
            tmr = pulse_ticks_ff;
         end
         if (ph == PhPulse && tmr == 8'd0) begin
            ph = PhWait;
         end
      end

      diff    = tc - es;
      us_wide = UsCmpWidth'(diff[CountWidth-1:1]);
      if (us_wide > UsCmpWidth'(UsSatMax)) begin
         us_in = UsSatMax;
      end else begin
         us_in = us_wide[UsWidth-1:0];
      end

      phase_in         = ph;
      phase_timer_in   = tmr;
      echo_start_in    = es;
      tick_count_in    = tc + CountWidth'(1);
      fin_in           = fin;
      flags_in.trigger = (ph == PhPulse);
      flags_in.ready   = (ph == PhDone);
      flags_in.busy    = (ph == PhSettle) || (ph == PhPulse) || (ph == PhWait) ||
                         (ph == PhMeasure);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhReady;
         tick_count_ff  <= '0;
         echo_start_ff  <= '0;
         phase_timer_ff <= 8'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         echo_start_ff  <= echo_start_in;
         phase_timer_ff <= phase_timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_flags_ff <= flags_in;
         s1_fin_ff   <= fin_in;
         s1_us_ff    <= us_in;
      end
   end

   assign cm_prod = 31'(s1_us_ff) * 31'(CmRecip);
   assign cm_raw  = 10'(cm_prod >> CmShift);
   assign cm_in   = (cm_raw > 10'(CmMax)) ? CmMax : cm_raw[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_flags_ff <= s1_flags_ff;
         s2_fin_ff   <= s1_fin_ff;
         s2_cm_ff    <= cm_in;
      end
   end

   assign byte_prod = 35'(s2_cm_ff) * 35'(ByteRecip);
   assign byte_in   = 8'(byte_prod >> ByteShift);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         held_cm_ff    <= 9'd0;
         held_byte_ff  <= 8'd0;
      end else if (pipe_en) begin
         rsp_tvalid_ff <= s2_valid_ff;
         if (s2_valid_ff && s2_fin_ff) begin
            held_cm_ff   <= s2_cm_ff;
            held_byte_ff <= byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_flags_ff <= s2_flags_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, held_byte_ff, held_cm_ff, rsp_flags_ff.busy,
                        rsp_flags_ff.ready, rsp_flags_ff.trigger};

   `UER_ASSERT_ALWAYS(a_held_cm_range, held_cm_ff <= CmMax, "held distance above 400 cm")
   `UER_ASSERT_ALWAYS(a_trigger_busy, !(rsp_tvalid_ff && rsp_flags_ff.trigger) || (rsp_flags_ff.busy && !rsp_flags_ff.ready), "trigger driven outside busy phase")
   `UER_ASSERT_ALWAYS(a_busy_ready_excl, !(s1_valid_ff && s1_flags_ff.busy && s1_flags_ff.ready), "busy and ready both set")
   `UER_ASSERT_NEXT(a_held_stable, !(pipe_en && s2_valid_ff && s2_fin_ff), $stable(held_cm_ff) && $stable(held_byte_ff), "held reading changed without a finished measurement")

endmodule

`default_nettype wire
